>>> sv/ir_manchester_frame_sender_unit_assert.svh
// assertion macros shared by the ir manchester frame sender rtl
// depends on: a clock named clk and a synchronous reset named rst in the using module
`ifndef IR_MANCHESTER_FRAME_SENDER_UNIT_ASSERT_SVH
`define IR_MANCHESTER_FRAME_SENDER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define IRMFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IRMFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/irmfs_pkg.sv
// shared types and constants for the ir manchester frame sender
// no dependencies
`default_nettype none

package irmfs_pkg;

  localparam int WORDS_PER_FRAME = 4;
  localparam int BITS_PER_WORD   = 8;
  localparam int LOADED_WORDS    = 4;
  localparam int WORD_W          = 16;
  localparam int WORD_TOP_BIT    = WORD_W - 1;
  localparam int CNT_W           = 4;
  localparam int BIT_IDX_W       = 4;
  localparam int WSEL_W          = $clog2(LOADED_WORDS);
  localparam int WIDX_MIN_W      = $clog2(WORDS_PER_FRAME + 1);
  localparam int WIDX_W          = (WIDX_MIN_W > WSEL_W) ? WIDX_MIN_W : WSEL_W + 1;
  localparam int FUNC_W          = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 4;

  localparam logic [CNT_W-1:0] HEADER_TICKS_RESET = CNT_W'(6);
  localparam logic [CNT_W-1:0] PAUSE_TICKS_RESET  = CNT_W'(3);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_LOAD  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_TICKS = 1'b0,
    REG_PAUSE_TICKS  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic carrier_on;
    logic sending;
    logic frame_done;
    logic load_taken;
  } result_t;

endpackage

`default_nettype wire

>>> sv/irmfs_core.sv
// command decode and frame sequencing state of the ir manchester frame sender
// depends on: irmfs_pkg, ir_manchester_frame_sender_unit_assert.svh
`default_nettype none

`include "ir_manchester_frame_sender_unit_assert.svh"

module irmfs_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic [irmfs_pkg::FUNC_W-1:0]  func,
  input  wire logic [irmfs_pkg::WORD_W-1:0]  word_a,
  input  wire logic [irmfs_pkg::WORD_W-1:0]  word_b,
  input  wire logic [irmfs_pkg::WORD_W-1:0]  word_c,
  input  wire logic [irmfs_pkg::WORD_W-1:0]  word_d,
  input  wire logic [irmfs_pkg::CNT_W-1:0]   header_ticks,
  input  wire logic [irmfs_pkg::CNT_W-1:0]   pause_ticks,
  output irmfs_pkg::result_t                 result
);
  import irmfs_pkg::*;

  logic                 carrier_level, carrier_level_next;
  logic [CNT_W-1:0]     header_left, header_left_next;
  logic                 header_started, header_started_next;
  logic                 active, active_next;
  logic [CNT_W-1:0]     pause_left, pause_left_next;
  logic                 half_phase, half_phase_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [WIDX_W-1:0]    word_index, word_index_next;
  logic [WORD_W-1:0]    frame_words [LOADED_WORDS];

  logic                 done;
  logic                 taken;
  logic                 load_words;
  logic [WORD_W-1:0]    cur_word;
  logic                 cur_bit;
  logic [BIT_IDX_W:0]   bit_inc;
  func_t                cmd;

  assign cmd = func_t'(func);

  // words past the loaded ones go out as zero
  always_comb begin
    if (word_index < WIDX_W'(LOADED_WORDS)) begin
      cur_word = frame_words[word_index[WSEL_W-1:0]];
    end else begin
      cur_word = '0;
    end
  end

  assign cur_bit = cur_word[BIT_IDX_W'(WORD_TOP_BIT) - bit_index];
  assign bit_inc = {1'b0, bit_index} + (BIT_IDX_W+1)'(1);

  always_comb begin
    carrier_level_next  = carrier_level;
    header_left_next    = header_left;
    header_started_next = header_started;
    active_next         = active;
    pause_left_next     = pause_left;
    half_phase_next     = half_phase;
    bit_index_next      = bit_index;
    word_index_next     = word_index;
    done                = 1'b0;
    taken               = 1'b0;
    load_words          = 1'b0;
    case (cmd)
      FUNC_TICK: begin
        if (header_left != '0) begin
          header_left_next = header_left - CNT_W'(1);
        end else if (active) begin
          if (pause_left != '0) begin
            pause_left_next    = pause_left - CNT_W'(1);
            carrier_level_next = 1'b0;
          end else if (word_index < WIDX_W'(WORDS_PER_FRAME)) begin
            // manchester: bit first, then its inverse
            carrier_level_next = cur_bit ^ half_phase;
            half_phase_next    = ~half_phase;
            if (half_phase) begin
              if (bit_inc >= (BIT_IDX_W+1)'(BITS_PER_WORD)) begin
                bit_index_next  = '0;
                word_index_next = word_index + WIDX_W'(1);
              end else begin
                bit_index_next = bit_inc[BIT_IDX_W-1:0];
              end
            end
          end else begin
            carrier_level_next  = 1'b0;
            active_next         = 1'b0;
            header_started_next = 1'b0;
            done                = 1'b1;
          end
        end
      end
      FUNC_START: begin
        carrier_level_next  = 1'b1;
        header_left_next    = header_ticks;
        header_started_next = 1'b1;
      end
      FUNC_LOAD: begin
        if (header_started) begin
          load_words      = 1'b1;
          half_phase_next = 1'b0;
          bit_index_next  = '0;
          word_index_next = '0;
          pause_left_next = pause_ticks;
          active_next     = 1'b1;
          taken           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_level  <= 1'b0;
      header_left    <= '0;
      header_started <= 1'b0;
      active         <= 1'b0;
      pause_left     <= '0;
      half_phase     <= 1'b0;
      bit_index      <= '0;
      word_index     <= '0;
    end else if (fire) begin
      carrier_level  <= carrier_level_next;
      header_left    <= header_left_next;
      header_started <= header_started_next;
      active         <= active_next;
      pause_left     <= pause_left_next;
      half_phase     <= half_phase_next;
      bit_index      <= bit_index_next;
      word_index     <= word_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && load_words) begin
      frame_words[0] <= word_a;
      frame_words[1] <= word_b;
      frame_words[2] <= word_c;
      frame_words[3] <= word_d;
    end
  end

  assign result.carrier_on = carrier_level_next;
  assign result.sending    = active_next;
  assign result.frame_done = done;
  assign result.load_taken = taken;

  `IRMFS_ASSERT_NOW(a_done_ends_frame, fire && done, !active_next && !carrier_level_next && !taken, "frame done while still sending")
  `IRMFS_ASSERT_NOW(a_load_needs_header, fire && cmd == FUNC_LOAD && !header_started, !taken && !load_words, "load taken without a started header")
  `IRMFS_ASSERT_NEXT(a_start_sets_carrier, fire && cmd == FUNC_START, carrier_level && header_started, "start did not raise carrier")
  `IRMFS_ASSERT_NEXT(a_pause_holds_off, fire && cmd == FUNC_TICK && header_left == '0 && active && pause_left != '0, !carrier_level && pause_left == $past(pause_left) - CNT_W'(1), "pause tick did not hold carrier off")
  `IRMFS_ASSERT_NOW(a_word_index_bound, active, word_index <= WIDX_W'(WORDS_PER_FRAME), "word index past frame end")

endmodule

`default_nettype wire

>>> sv/ir_manchester_frame_sender_unit.sv
// top level of the ir manchester frame sender: config registers and result buffer
// depends on: irmfs_pkg, irmfs_core, ir_manchester_frame_sender_unit_assert.svh
//
//   channel   handshake               payload
//   command   cmd_valid / cmd_ready   func, word_a, word_b, word_c, word_d
//   result    res_valid / res_ready   carrier_on, sending, frame_done, load_taken
//   config    cfg_we                  cfg_index, cfg_data
//
// one command per cycle while cmd_ready is high; its result is registered
// the result side has an output register plus a skid entry, so cmd_ready only drops
// once both hold results that are not yet taken
// rst clears the sequencing state, the config registers (header 6, pause 3) and the buffer
// frame words hold no reset value and are written by each accepted load
`default_nettype none

`include "ir_manchester_frame_sender_unit_assert.svh"

module ir_manchester_frame_sender_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_ready,
  input  wire logic [irmfs_pkg::FUNC_W-1:0]      func,
  input  wire logic [irmfs_pkg::WORD_W-1:0]      word_a,
  input  wire logic [irmfs_pkg::WORD_W-1:0]      word_b,
  input  wire logic [irmfs_pkg::WORD_W-1:0]      word_c,
  input  wire logic [irmfs_pkg::WORD_W-1:0]      word_d,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output logic                                   carrier_on,
  output logic                                   sending,
  output logic                                   frame_done,
  output logic                                   load_taken,
  input  wire logic                              cfg_we,
  input  wire logic [irmfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [irmfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import irmfs_pkg::*;

  logic [CNT_W-1:0] header_ticks;
  logic [CNT_W-1:0] pause_ticks;
  logic             cmd_fire;
  logic             res_fire;
  result_t          new_result;
  result_t          res_data;
  result_t          skid_data;
  logic             skid_valid;

  assign cmd_ready = ~skid_valid;
  assign cmd_fire  = cmd_valid & cmd_ready;
  assign res_fire  = res_valid & res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_ticks <= HEADER_TICKS_RESET;
      pause_ticks  <= PAUSE_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADER_TICKS: header_ticks <= cfg_data[CNT_W-1:0];
        REG_PAUSE_TICKS:  pause_ticks  <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  irmfs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (cmd_fire),
    .func         (func),
    .word_a       (word_a),
    .word_b       (word_b),
    .word_c       (word_c),
    .word_d       (word_d),
    .header_ticks (header_ticks),
    .pause_ticks  (pause_ticks),
    .result       (new_result)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!res_valid || res_fire) begin
        if (skid_valid) begin
          res_valid  <= 1'b1;
          res_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          res_valid <= cmd_fire;
          res_data  <= new_result;
        end
      end else if (cmd_fire) begin
        skid_valid <= 1'b1;
        skid_data  <= new_result;
      end
    end
  end

  assign carrier_on = res_data.carrier_on;
  assign sending    = res_data.sending;
  assign frame_done = res_data.frame_done;
  assign load_taken = res_data.load_taken;

  `IRMFS_ASSERT_NOW(a_skid_behind_output, skid_valid, res_valid, "skid entry holds a result ahead of the output register")
  `IRMFS_ASSERT_NEXT(a_stall_fills_skid, res_valid && !res_ready && cmd_fire, skid_valid, "transfer lost while output stalled")
  `IRMFS_ASSERT_NEXT(a_transfer_shows_result, cmd_fire && !skid_valid && (!res_valid || res_ready), res_valid, "transfer produced no result")

endmodule

`default_nettype wire
